@@ rtl/cpr_pkg.sv @@
package cpr_pkg;

    localparam int SAMPLE_BITS_DEF    = 16;
    localparam int TRIG_FRAC_BITS_DEF = 8;
    localparam int OUT_BITS           = 26;
    localparam int CARRIER_BITS       = 10;
    localparam int OFFSET_BITS        = 11;
    localparam int UNIT_BITS          = 12;
    localparam int CFG_DATA_BITS      = 12;
    localparam int CFG_INDEX_BITS     = 1;
    localparam int KSUM_BITS          = 11;
    localparam int PA_BITS            = 22;
    localparam int MAG_BITS           = 34;
    localparam int Q_BITS             = 64;

    localparam logic [UNIT_BITS-1:0]    PHASE_UNIT_RESET    = 12'd178;
    localparam logic [CARRIER_BITS-1:0] FIRST_CARRIER_RESET = 10'd0;

    localparam logic [Q_BITS-1:0] INV_2PI_Q64 = 64'h28BE_60DB_9391_054A;
    localparam logic [Q_BITS-1:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;
    localparam logic [Q_BITS-1:0] ONE_Q62     = 64'h4000_0000_0000_0000;
    localparam logic [61:0]       OCTANT_Q62  = 62'h2000_0000_0000_0000;

    localparam int TERMS     = 12;
    localparam int ANGLE_LAT = 9;
    localparam int TERM_LAT  = 7;
    localparam int TRIG_LAT  = ANGLE_LAT + TERMS * TERM_LAT;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_PHASE_UNIT    = 1'b0,
        REG_FIRST_CARRIER = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    typedef struct packed {
        logic  valid;
        logic  zero;
        logic  neg;
        logic  swap;
        quad_t quad;
    } ctl_t;

endpackage

@@ rtl/cpr_mul64.sv @@
module cpr_mul64 (
    input  logic         aclk,
    input  logic         en,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    output logic [127:0] prod
);

    logic [63:0]  ll_reg;
    logic [63:0]  lh_reg;
    logic [63:0]  hl_reg;
    logic [63:0]  hh_reg;
    logic [127:0] prod_reg;
    logic [64:0]  mid;

    // partial products
    always_ff @(posedge aclk) begin
        if (en) begin
            ll_reg <= 64'(a[31:0])  * 64'(b[31:0]);
            lh_reg <= 64'(a[31:0])  * 64'(b[63:32]);
            hl_reg <= 64'(a[63:32]) * 64'(b[31:0]);
            hh_reg <= 64'(a[63:32]) * 64'(b[63:32]);
        end
    end

    assign mid = 65'(lh_reg) + 65'(hl_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= {hh_reg, ll_reg} + {31'd0, mid, 32'd0};
        end
    end

    assign prod = prod_reg;

endmodule

@@ rtl/cpr_div.sv @@
module cpr_div #(
    parameter int unsigned DIV = 2
) (
    input  logic        aclk,
    input  logic        en,
    input  logic [63:0] x,
    output logic [63:0] q
);

    localparam logic [64:0] TWO_64 = 65'd1 << 64;
    localparam logic [63:0] RECIP  = 64'(TWO_64 / DIV);

    logic [127:0] prod;
    logic [63:0]  x_dly_reg [0:1];
    logic [63:0]  q0_reg;
    logic [63:0]  rem_reg;
    logic [63:0]  q_reg;

    cpr_mul64 u_recip (
        .aclk (aclk),
        .en   (en),
        .a    (x),
        .b    (RECIP),
        .prod (prod)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            x_dly_reg[0] <= x;
            x_dly_reg[1] <= x_dly_reg[0];
            q0_reg       <= prod[127:64];
            rem_reg      <= x_dly_reg[1] - 64'(prod[127:64] * 64'(DIV));
            // estimate is at most one low
            q_reg        <= (rem_reg >= 64'(DIV)) ? q0_reg + 64'd1 : q0_reg;
        end
    end

    assign q = q_reg;

endmodule

@@ rtl/cpr_term.sv @@
module cpr_term #(
    parameter int unsigned ORDER = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic [63:0]   ts_in,
    input  logic [63:0]   tc_in,
    input  logic [63:0]   ss_in,
    input  logic [63:0]   sc_in,
    input  logic [63:0]   x2_in,
    input  cpr_pkg::ctl_t ctl_in,
    output logic [63:0]   ts_out,
    output logic [63:0]   tc_out,
    output logic [63:0]   ss_out,
    output logic [63:0]   sc_out,
    output logic [63:0]   x2_out,
    output cpr_pkg::ctl_t ctl_out
);

    localparam int unsigned DIV_S    = (2 * ORDER) * (2 * ORDER + 1);
    localparam int unsigned DIV_C    = (2 * ORDER - 1) * (2 * ORDER);
    localparam int          DLY      = cpr_pkg::TERM_LAT - 1;
    localparam bit          SUBTRACT = (ORDER % 2) == 1;

    logic [127:0]  prod_s;
    logic [127:0]  prod_c;
    logic [63:0]   ts_q;
    logic [63:0]   tc_q;
    logic [63:0]   ss_dly_reg  [0:DLY-1];
    logic [63:0]   sc_dly_reg  [0:DLY-1];
    logic [63:0]   x2_dly_reg  [0:DLY-1];
    cpr_pkg::ctl_t ctl_dly_reg [0:DLY-1];
    logic [63:0]   ts_reg;
    logic [63:0]   tc_reg;
    logic [63:0]   ss_reg;
    logic [63:0]   sc_reg;
    logic [63:0]   x2_reg;
    cpr_pkg::ctl_t ctl_reg;

    cpr_mul64 u_mul_s (
        .aclk (aclk),
        .en   (en),
        .a    (ts_in),
        .b    (x2_in),
        .prod (prod_s)
    );

    cpr_mul64 u_mul_c (
        .aclk (aclk),
        .en   (en),
        .a    (tc_in),
        .b    (x2_in),
        .prod (prod_c)
    );

    cpr_div #(.DIV(DIV_S)) u_div_s (
        .aclk (aclk),
        .en   (en),
        .x    (prod_s[125:62]),
        .q    (ts_q)
    );

    cpr_div #(.DIV(DIV_C)) u_div_c (
        .aclk (aclk),
        .en   (en),
        .x    (prod_c[125:62]),
        .q    (tc_q)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            ss_dly_reg[0] <= ss_in;
            sc_dly_reg[0] <= sc_in;
            x2_dly_reg[0] <= x2_in;
            for (int i = 1; i < DLY; i++) begin
                ss_dly_reg[i] <= ss_dly_reg[i-1];
                sc_dly_reg[i] <= sc_dly_reg[i-1];
                x2_dly_reg[i] <= x2_dly_reg[i-1];
            end
            ts_reg <= ts_q;
            tc_reg <= tc_q;
            x2_reg <= x2_dly_reg[DLY-1];
            // alternating series signs
            if (SUBTRACT) begin
                ss_reg <= ss_dly_reg[DLY-1] - ts_q;
                sc_reg <= sc_dly_reg[DLY-1] - tc_q;
            end else begin
                ss_reg <= ss_dly_reg[DLY-1] + ts_q;
                sc_reg <= sc_dly_reg[DLY-1] + tc_q;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DLY; i++) begin
                ctl_dly_reg[i] <= '0;
            end
            ctl_reg <= '0;
        end else if (en) begin
            ctl_dly_reg[0] <= ctl_in;
            for (int i = 1; i < DLY; i++) begin
                ctl_dly_reg[i] <= ctl_dly_reg[i-1];
            end
            ctl_reg <= ctl_dly_reg[DLY-1];
        end
    end

    assign ts_out  = ts_reg;
    assign tc_out  = tc_reg;
    assign ss_out  = ss_reg;
    assign sc_out  = sc_reg;
    assign x2_out  = x2_reg;
    assign ctl_out = ctl_reg;

endmodule

@@ rtl/cpr_angle.sv @@
module cpr_angle (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               en,
    input  logic                               valid_in,
    input  logic [cpr_pkg::UNIT_BITS-1:0]      phase_unit,
    input  logic [cpr_pkg::CARRIER_BITS-1:0]   first_carrier,
    input  logic [cpr_pkg::CARRIER_BITS-1:0]   carrier_index,
    input  logic [cpr_pkg::OFFSET_BITS-1:0]    time_offset,
    output logic [63:0]                        x_out,
    output logic [63:0]                        x2_out,
    output cpr_pkg::ctl_t                      ctl_out
);

    localparam int CTL_STAGES = cpr_pkg::ANGLE_LAT - 2;

    logic [cpr_pkg::OFFSET_BITS-1:0] aoff;
    logic                            valid1_reg;
    logic                            neg1_reg;
    logic [cpr_pkg::KSUM_BITS-1:0]   k1_reg;
    logic [cpr_pkg::PA_BITS-1:0]     pa1_reg;
    logic                            valid2_reg;
    logic                            neg2_reg;
    logic [cpr_pkg::MAG_BITS-1:0]    mag2_reg;
    logic [127:0]                    prod_turn;
    logic [127:0]                    prod_fold;
    logic [127:0]                    prod_sq;
    logic [63:0]                     turns;
    logic [61:0]                     rem;
    logic                            swap_next;
    logic [63:0]                     arg_next;
    logic [63:0]                     arg_reg;
    logic [63:0]                     x;
    logic [63:0]                     x_dly_reg [0:1];
    cpr_pkg::ctl_t                   ctl_reg [0:CTL_STAGES-1];

    assign aoff = time_offset[cpr_pkg::OFFSET_BITS-1] ? (~time_offset + 1'b1) : time_offset;

    always_ff @(posedge aclk) begin
        if (en) begin
            k1_reg   <= cpr_pkg::KSUM_BITS'(first_carrier) + cpr_pkg::KSUM_BITS'(carrier_index);
            pa1_reg  <= cpr_pkg::PA_BITS'(phase_unit) * cpr_pkg::PA_BITS'(aoff);
            neg1_reg <= !time_offset[cpr_pkg::OFFSET_BITS-1] && (time_offset != '0);
            neg2_reg <= neg1_reg;
            mag2_reg <= (cpr_pkg::MAG_BITS'(pa1_reg) * cpr_pkg::MAG_BITS'(k1_reg)) << 1;
        end
    end

    cpr_mul64 u_turn (
        .aclk (aclk),
        .en   (en),
        .a    (64'(mag2_reg)),
        .b    (cpr_pkg::INV_2PI_Q64),
        .prod (prod_turn)
    );

    // fraction of a turn, then fold into the lower half of the quadrant
    assign turns     = prod_turn[79:16];
    assign rem       = turns[61:0];
    assign swap_next = rem > cpr_pkg::OCTANT_Q62;
    assign arg_next  = swap_next ? cpr_pkg::ONE_Q62 - 64'(rem) : 64'(rem);

    always_ff @(posedge aclk) begin
        if (en) begin
            arg_reg <= arg_next;
        end
    end

    cpr_mul64 u_fold (
        .aclk (aclk),
        .en   (en),
        .a    (arg_reg),
        .b    (cpr_pkg::HALF_PI_Q62),
        .prod (prod_fold)
    );

    assign x = prod_fold[125:62];

    cpr_mul64 u_sq (
        .aclk (aclk),
        .en   (en),
        .a    (x),
        .b    (x),
        .prod (prod_sq)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            x_dly_reg[0] <= x;
            x_dly_reg[1] <= x_dly_reg[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            for (int i = 0; i < CTL_STAGES; i++) begin
                ctl_reg[i] <= '0;
            end
        end else if (en) begin
            valid1_reg       <= valid_in;
            valid2_reg       <= valid1_reg;
            ctl_reg[0].valid <= valid2_reg;
            ctl_reg[0].zero  <= mag2_reg == '0;
            ctl_reg[0].neg   <= neg2_reg;
            ctl_reg[0].swap  <= 1'b0;
            ctl_reg[0].quad  <= cpr_pkg::QUAD_0;
            ctl_reg[1]       <= ctl_reg[0];
            ctl_reg[2].valid <= ctl_reg[1].valid;
            ctl_reg[2].zero  <= ctl_reg[1].zero;
            ctl_reg[2].neg   <= ctl_reg[1].neg;
            ctl_reg[2].swap  <= swap_next;
            ctl_reg[2].quad  <= cpr_pkg::quad_t'(turns[63:62]);
            for (int i = 3; i < CTL_STAGES; i++) begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
        end
    end

    assign x_out   = x_dly_reg[1];
    assign x2_out  = prod_sq[125:62];
    assign ctl_out = ctl_reg[CTL_STAGES-1];

endmodule

@@ rtl/cpr_rotate.sv @@
module cpr_rotate #(
    parameter int SAMPLE_BITS    = cpr_pkg::SAMPLE_BITS_DEF,
    parameter int TRIG_FRAC_BITS = cpr_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic [63:0]                         ss,
    input  logic [63:0]                         sc,
    input  cpr_pkg::ctl_t                       ctl,
    input  logic signed [SAMPLE_BITS-1:0]       sample_re,
    input  logic signed [SAMPLE_BITS-1:0]       sample_im,
    output logic                                valid_out,
    output logic signed [cpr_pkg::OUT_BITS-1:0] rotated_re,
    output logic signed [cpr_pkg::OUT_BITS-1:0] rotated_im
);

    localparam int CW = TRIG_FRAC_BITS + 3;
    localparam int PW = CW + SAMPLE_BITS;
    localparam int SH = 62 - TRIG_FRAC_BITS;

    logic [63:0]                         sn;
    logic [63:0]                         cs;
    logic [63:0]                         cabs;
    logic [63:0]                         sabs;
    logic                                cneg;
    logic                                sneg;
    logic signed [CW-1:0]                cmag;
    logic signed [CW-1:0]                smag;
    logic signed [CW-1:0]                c_next;
    logic signed [CW-1:0]                s_next;
    logic signed [CW-1:0]                c_reg;
    logic signed [CW-1:0]                s_reg;
    logic signed [SAMPLE_BITS-1:0]       re_reg;
    logic signed [SAMPLE_BITS-1:0]       im_reg;
    logic signed [PW-1:0]                p_cr_reg;
    logic signed [PW-1:0]                p_si_reg;
    logic signed [PW-1:0]                p_ci_reg;
    logic signed [PW-1:0]                p_sr_reg;
    logic signed [PW:0]                  sum_re;
    logic signed [PW:0]                  sum_im;
    logic signed [cpr_pkg::OUT_BITS-1:0] rot_re_reg;
    logic signed [cpr_pkg::OUT_BITS-1:0] rot_im_reg;
    logic                                valid1_reg;
    logic                                valid2_reg;
    logic                                valid3_reg;

    // on the upper half of a quadrant the series ran on the complement
    assign sn = ctl.swap ? sc : ss;
    assign cs = ctl.swap ? ss : sc;

    always_comb begin
        case (ctl.quad)
            cpr_pkg::QUAD_0: begin
                cabs = cs; cneg = 1'b0; sabs = sn; sneg = 1'b0;
            end
            cpr_pkg::QUAD_1: begin
                cabs = sn; cneg = 1'b1; sabs = cs; sneg = 1'b0;
            end
            cpr_pkg::QUAD_2: begin
                cabs = cs; cneg = 1'b1; sabs = sn; sneg = 1'b1;
            end
            cpr_pkg::QUAD_3: begin
                cabs = sn; cneg = 1'b0; sabs = cs; sneg = 1'b1;
            end
            default: begin
                cabs = cs; cneg = 1'b0; sabs = sn; sneg = 1'b0;
            end
        endcase
    end

    // truncate magnitude, then apply sign
    assign cmag = signed'({1'b0, cabs[63:SH]});
    assign smag = signed'({1'b0, sabs[63:SH]});

    always_comb begin
        if (ctl.zero) begin
            c_next = signed'(CW'(1) << TRIG_FRAC_BITS);
            s_next = '0;
        end else begin
            c_next = cneg ? -cmag : cmag;
            s_next = (sneg ^ ctl.neg) ? -smag : smag;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_reg    <= c_next;
            s_reg    <= s_next;
            re_reg   <= sample_re;
            im_reg   <= sample_im;
            p_cr_reg <= PW'(c_reg) * PW'(re_reg);
            p_si_reg <= PW'(s_reg) * PW'(im_reg);
            p_ci_reg <= PW'(c_reg) * PW'(im_reg);
            p_sr_reg <= PW'(s_reg) * PW'(re_reg);
        end
    end

    assign sum_re = (PW+1)'(p_cr_reg) - (PW+1)'(p_si_reg);
    assign sum_im = (PW+1)'(p_ci_reg) + (PW+1)'(p_sr_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            rot_re_reg <= cpr_pkg::OUT_BITS'(sum_re);
            rot_im_reg <= cpr_pkg::OUT_BITS'(sum_im);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
        end else if (en) begin
            valid1_reg <= ctl.valid;
            valid2_reg <= valid1_reg;
            valid3_reg <= valid2_reg;
        end
    end

    assign valid_out  = valid3_reg;
    assign rotated_re = rot_re_reg;
    assign rotated_im = rot_im_reg;

endmodule

@@ rtl/carrier_phase_rotator.sv @@
// Rotates each complex pilot word by -2*phase_unit*time_offset*(first_carrier+carrier_index)
// /65536 radians and returns the product in Q(TRIG_FRAC_BITS). The core is a fixed pipeline
// of 96 register stages plus an output register with a one-word skid, and one word per
// cycle is sustained while m_tready stays high; most of the depth comes from the
// twelve-term sine/cosine series, each term a pair of 64-bit multiplies and reciprocal
// divides built from 32x32 partial products. s_tready drops only while the skid word is
// held. Registers: index 0 phase_unit (reset 178), index 1 first_carrier (reset 0); write
// them only while no word is in flight. Outputs wrap to 26 bits.
module carrier_phase_rotator #(
    parameter  int SAMPLE_BITS    = cpr_pkg::SAMPLE_BITS_DEF,
    parameter  int TRIG_FRAC_BITS = cpr_pkg::TRIG_FRAC_BITS_DEF,
    localparam int IN_BITS        = 2 * SAMPLE_BITS + cpr_pkg::CARRIER_BITS
                                    + cpr_pkg::OFFSET_BITS,
    localparam int S_TDATA_W      = ((IN_BITS + 7) / 8) * 8,
    localparam int M_TDATA_W      = ((2 * cpr_pkg::OUT_BITS + 7) / 8) * 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [cpr_pkg::CFG_INDEX_BITS-1:0]  cfg_wr_index,
    input  logic [cpr_pkg::CFG_DATA_BITS-1:0]   cfg_wr_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // sample_re, sample_im, carrier_index, time_offset
    input  logic [S_TDATA_W-1:0]                s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // rotated_re, rotated_im
    output logic [M_TDATA_W-1:0]                m_tdata
);

    localparam int CI_LO  = 2 * SAMPLE_BITS;
    localparam int OFF_LO = CI_LO + cpr_pkg::CARRIER_BITS;
    localparam int LAT    = cpr_pkg::TRIG_LAT;

    logic [cpr_pkg::UNIT_BITS-1:0]       phase_unit_reg;
    logic [cpr_pkg::CARRIER_BITS-1:0]    first_carrier_reg;
    logic                                en;
    logic                                accept;
    logic signed [SAMPLE_BITS-1:0]       re_dly_reg [0:LAT-1];
    logic signed [SAMPLE_BITS-1:0]       im_dly_reg [0:LAT-1];
    logic [63:0]                         ts_w  [0:cpr_pkg::TERMS];
    logic [63:0]                         tc_w  [0:cpr_pkg::TERMS];
    logic [63:0]                         ss_w  [0:cpr_pkg::TERMS];
    logic [63:0]                         sc_w  [0:cpr_pkg::TERMS];
    logic [63:0]                         x2_w  [0:cpr_pkg::TERMS];
    cpr_pkg::ctl_t                       ctl_w [0:cpr_pkg::TERMS];
    logic [63:0]                         x;
    logic                                pipe_valid;
    logic signed [cpr_pkg::OUT_BITS-1:0] pipe_re;
    logic signed [cpr_pkg::OUT_BITS-1:0] pipe_im;
    logic                                out_valid_reg;
    logic signed [cpr_pkg::OUT_BITS-1:0] out_re_reg;
    logic signed [cpr_pkg::OUT_BITS-1:0] out_im_reg;
    logic                                skid_valid_reg;
    logic signed [cpr_pkg::OUT_BITS-1:0] skid_re_reg;
    logic signed [cpr_pkg::OUT_BITS-1:0] skid_im_reg;
    logic                                out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_unit_reg    <= cpr_pkg::PHASE_UNIT_RESET;
            first_carrier_reg <= cpr_pkg::FIRST_CARRIER_RESET;
        end else if (cfg_wr_en) begin
            case (cpr_pkg::cfg_reg_t'(cfg_wr_index))
                cpr_pkg::REG_PHASE_UNIT: begin
                    phase_unit_reg <= cfg_wr_data;
                end
                cpr_pkg::REG_FIRST_CARRIER: begin
                    first_carrier_reg <= cfg_wr_data[cpr_pkg::CARRIER_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // whole pipeline advances while the skid slot is empty
    assign en       = !skid_valid_reg;
    assign s_tready = en;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (en) begin
            re_dly_reg[0] <= signed'(s_tdata[SAMPLE_BITS-1:0]);
            im_dly_reg[0] <= signed'(s_tdata[CI_LO-1:SAMPLE_BITS]);
            for (int i = 1; i < LAT; i++) begin
                re_dly_reg[i] <= re_dly_reg[i-1];
                im_dly_reg[i] <= im_dly_reg[i-1];
            end
        end
    end

    cpr_angle u_angle (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (en),
        .valid_in      (accept),
        .phase_unit    (phase_unit_reg),
        .first_carrier (first_carrier_reg),
        .carrier_index (s_tdata[OFF_LO-1:CI_LO]),
        .time_offset   (s_tdata[OFF_LO+cpr_pkg::OFFSET_BITS-1:OFF_LO]),
        .x_out         (x),
        .x2_out        (x2_w[0]),
        .ctl_out       (ctl_w[0])
    );

    assign ts_w[0] = x;
    assign ss_w[0] = x;
    assign tc_w[0] = cpr_pkg::ONE_Q62;
    assign sc_w[0] = cpr_pkg::ONE_Q62;

    for (genvar n = 1; n <= cpr_pkg::TERMS; n++) begin : g_term
        cpr_term #(.ORDER(n)) u_term (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .ts_in   (ts_w[n-1]),
            .tc_in   (tc_w[n-1]),
            .ss_in   (ss_w[n-1]),
            .sc_in   (sc_w[n-1]),
            .x2_in   (x2_w[n-1]),
            .ctl_in  (ctl_w[n-1]),
            .ts_out  (ts_w[n]),
            .tc_out  (tc_w[n]),
            .ss_out  (ss_w[n]),
            .sc_out  (sc_w[n]),
            .x2_out  (x2_w[n]),
            .ctl_out (ctl_w[n])
        );
    end

    cpr_rotate #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_rotate (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .ss         (ss_w[cpr_pkg::TERMS]),
        .sc         (sc_w[cpr_pkg::TERMS]),
        .ctl        (ctl_w[cpr_pkg::TERMS]),
        .sample_re  (re_dly_reg[LAT-1]),
        .sample_im  (im_dly_reg[LAT-1]),
        .valid_out  (pipe_valid),
        .rotated_re (pipe_re),
        .rotated_im (pipe_im)
    );

    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= pipe_valid;
            end
        end else if (pipe_valid) begin
            // if en is high here, the pipeline word would otherwise be lost
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                out_re_reg <= skid_re_reg;
                out_im_reg <= skid_im_reg;
            end else begin
                out_re_reg <= pipe_re;
                out_im_reg <= pipe_im;
            end
        end else if (en) begin
            skid_re_reg <= pipe_re;
            skid_im_reg <= pipe_im;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({out_im_reg, out_re_reg});

endmodule
